[src/hsled_pkg.sv]
`timescale 1ns / 1ps

package hsled_pkg;

  // Reset values of the configuration registers
  localparam logic [7:0]  LED_MAX         = 8'd160;
  localparam logic [6:0]  AMBIENT_TEMP    = 7'd25;
  localparam logic [5:0]  HEAT_HYSTERESIS = 6'd3;
  localparam logic [15:0] UPDATE_PERIOD   = 16'd500;
  localparam logic [7:0]  FLASH_STEP      = 8'd2;

  localparam int unsigned HOTEND_COUNT_DEF = 1;

  // Configuration port
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 3;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Datapath widths
  localparam int unsigned HEAT_W  = 11;
  localparam int unsigned COLOR_W = 9;
  // 2 * 255 * 2047 stays below 2**20
  localparam int unsigned NUM_W   = 20;
  // every quotient stays below 2 * duty_max, so below 512
  localparam int unsigned QUO_W   = 9;

  // Flash phases with a meaning of their own
  localparam logic [2:0] PH_WHITE = 3'd6;
  localparam logic [2:0] PH_DELAY = 3'd7;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_REPORT  = 3'd1,
    OP_FLASH   = 3'd2,
    OP_FORCE   = 3'd3,
    OP_RELEASE = 3'd4,
    OP_NOP     = 3'd5
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DUTY_MAX         = 3'd0,
    CFG_AMBIENT_TEMP     = 3'd1,
    CFG_HEAT_HYSTERESIS  = 3'd2,
    CFG_UPDATE_PERIOD    = 3'd3,
    CFG_FLASH_STEP_TICKS = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAT,
    ST_DIV,
    ST_FIN
  } st_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [HEAT_W-1:0] current_heat_sum;
    logic [HEAT_W-1:0] target_heat_sum;
    logic [7:0]        force_red;
    logic [7:0]        force_green;
    logic [7:0]        force_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_duty;
    logic [7:0] green_duty;
    logic [7:0] blue_duty;
    logic       write_strobe;
    logic       animating;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [HEAT_W-1:0] current_heat_sum;
    logic [HEAT_W-1:0] target_heat_sum;
    logic [7:0]        force_red;
    logic [7:0]        force_green;
    logic [7:0]        force_blue;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    cmd_t       cmd;
  } queue_head_t;

  typedef struct packed {
    logic [7:0]  duty_max;
    logic [6:0]  ambient_temp;
    logic [5:0]  heat_hysteresis;
    logic [15:0] update_period;
    logic [7:0]  flash_step_ticks;
  } cfg_t;

  typedef struct packed {
    logic              done;
    logic [QUO_W-1:0]  quo;
    logic              rem_nz;
  } div_res_t;

endpackage

[src/hsled_if.sv]
`timescale 1ns / 1ps

// Input item channel
interface hsled_in_if
  import hsled_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result item channel
interface hsled_out_if
  import hsled_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/hsled_front.sv]
`timescale 1ns / 1ps

module hsled_front
  import hsled_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  hsled_in_if.sink    items,
  input  logic        pop,
  output queue_head_t head
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  cmd_t             cmd_in;

  // Classify the beat; unknown opcodes become no-ops
  always_comb begin
    cmd_in.current_heat_sum = items.data.current_heat_sum;
    cmd_in.target_heat_sum  = items.data.target_heat_sum;
    cmd_in.force_red        = items.data.force_red;
    cmd_in.force_green      = items.data.force_green;
    cmd_in.force_blue       = items.data.force_blue;
    if (items.data.opcode inside {OP_TICK, OP_REPORT, OP_FLASH, OP_FORCE, OP_RELEASE}) begin
      cmd_in.op = op_t'(items.data.opcode);
    end else begin
      cmd_in.op = OP_NOP;
    end
  end

  assign items.ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push        = items.valid && items.ready;

  // Store the command at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.cmd   = q_mem[rd_ptr];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("command queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty command queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CNT_W'(1))
    else $error("queue count did not grow on push");
`endif

endmodule

[src/hsled_div.sv]
`timescale 1ns / 1ps

module hsled_div
  import hsled_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [HEAT_W-1:0] den,
  output div_res_t          res
);

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic [QUO_W-1:0] quo;

  // Count the restoring steps, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(QUO_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Subtract the shifted divisor where it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= NUM_W'(den) << (QUO_W - 1);
      quo <= '0;
    end else if (cnt != '0) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign res.done   = done;
  assign res.quo    = quo;
  assign res.rem_nz = (rem != '0);

endmodule

[src/hsled_back.sv]
`timescale 1ns / 1ps

module hsled_back
  import hsled_pkg::*;
#(
  parameter int unsigned HOTEND_COUNT = HOTEND_COUNT_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  queue_head_t head,
  output logic        pop,
  hsled_out_if.source results
);

  localparam int unsigned ROOM_W = 7 + $clog2(HOTEND_COUNT + 1);
  localparam int unsigned SUB_W  = (ROOM_W > HEAT_W) ? ROOM_W : HEAT_W;

  typedef struct packed {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } rgb_t;

  function automatic logic [7:0] clamp_duty(input logic [COLOR_W-1:0] v,
                                            input logic [7:0] dmax);
    clamp_duty = (v > {1'b0, dmax}) ? dmax : v[7:0];
  endfunction

  // Control state
  st_t         state;
  st_t         state_next;
  rgb_t        sets [2];
  rgb_t        sets_next [2];
  logic [1:0]  dirty;
  logic [1:0]  dirty_next;
  logic        forced_active;
  logic        forced_next;
  logic        flash_pending;
  logic        flash_next;
  logic [2:0]  ramp_phase;
  logic [2:0]  phase_next;
  logic [7:0]  ramp_level;
  logic [7:0]  level_next;
  logic [7:0]  step_cd;
  logic [7:0]  step_cd_next;
  logic [15:0] update_cd;
  logic [15:0] update_cd_next;
  logic        out_valid;

  // Payload registers
  logic [HEAT_W-1:0] cur_r;
  logic [HEAT_W-1:0] tgt_r;
  rgb_t              fin_rgb;
  out_item_t         out_data;
  out_item_t         out_next;

  // Sequencer strobes
  logic take;
  logic report_go;
  logic heat_white;
  logic exec;
  logic emit;
  logic div_start;
  logic fin_white;
  logic fin_div;
  logic fin_apply;

  // Datapath helpers
  logic [ROOM_W-1:0]  room_prod;
  logic [SUB_W-1:0]   room_ext;
  logic [SUB_W-1:0]   cur_ext;
  logic [SUB_W-1:0]   tgt_ext;
  logic [HEAT_W-1:0]  cur_clamp;
  logic [HEAT_W-1:0]  tgt_clamp;
  logic [COLOR_W-1:0] m2;
  logic [NUM_W-1:0]   product;
  logic [COLOR_W-1:0] white;
  logic [COLOR_W-1:0] lvl9;
  rgb_t               ramp_color;
  logic [2:0]         phase_adv;
  logic [7:0]         level_adv;
  logic [7:0]         step_dec;
  logic               color_we;
  rgb_t               color;
  rgb_t               active;
  div_res_t           res;

  assign take = head.valid && (!out_valid || results.ready);
  assign report_go = (head.cmd.op == OP_REPORT) && !forced_active && !flash_pending
                     && (update_cd == '0);

  // Heat relative to room, clamped at zero
  assign room_prod = ROOM_W'(HOTEND_COUNT) * ROOM_W'(cfg.ambient_temp);
  assign room_ext  = SUB_W'(room_prod);
  assign cur_ext   = SUB_W'(head.cmd.current_heat_sum);
  assign tgt_ext   = SUB_W'(head.cmd.target_heat_sum);
  assign cur_clamp = (cur_ext > room_ext) ? HEAT_W'(cur_ext - room_ext) : '0;
  assign tgt_clamp = (tgt_ext > room_ext) ? HEAT_W'(tgt_ext - room_ext) : '0;

  assign m2         = {cfg.duty_max, 1'b0};
  assign product    = NUM_W'(m2) * NUM_W'(cur_r);
  assign white      = {1'b0, cfg.duty_max};
  assign heat_white = (tgt_r == '0)
                      || (({1'b0, cur_r} + (HEAT_W + 1)'(cfg.heat_hysteresis))
                          >= {1'b0, tgt_r});

  hsled_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (product),
    .den   (tgt_r),
    .res   (res)
  );

  // Flash ramp color and the step after it
  always_comb begin
    lvl9       = {1'b0, ramp_level};
    ramp_color = '0;
    if (ramp_phase inside {PH_WHITE, PH_DELAY}) begin
      ramp_color = '{r: lvl9, g: lvl9, b: lvl9};
    end else if (ramp_phase[2:1] == 2'd0) begin
      ramp_color.r = lvl9;
    end else if (ramp_phase[2:1] == 2'd1) begin
      ramp_color.g = lvl9;
    end else begin
      ramp_color.b = lvl9;
    end
    phase_adv = ramp_phase + 3'd1;
    if (!ramp_phase[0]) begin
      if (({1'b0, ramp_level} + 9'd1) >= {1'b0, cfg.duty_max}) begin
        level_adv = (phase_adv == PH_DELAY) ? 8'd0 : cfg.duty_max;
      end else begin
        phase_adv = ramp_phase;
        level_adv = ramp_level + 8'd1;
      end
    end else begin
      if (ramp_level <= 8'd1) begin
        level_adv = 8'd0;
      end else begin
        phase_adv = ramp_phase;
        level_adv = ramp_level - 8'd1;
      end
    end
  end

  // Next state of the sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && report_go) begin
          state_next = ST_HEAT;
        end
      end
      ST_HEAT: state_next = heat_white ? ST_FIN : ST_DIV;
      ST_DIV: begin
        if (res.done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop       = 1'b0;
    exec      = 1'b0;
    emit      = 1'b0;
    div_start = 1'b0;
    fin_white = 1'b0;
    fin_div   = 1'b0;
    fin_apply = 1'b0;
    case (state)
      ST_IDLE: begin
        pop  = take;
        exec = take;
        emit = take && !report_go;
      end
      ST_HEAT: begin
        div_start = !heat_white;
        fin_white = heat_white;
      end
      ST_DIV:  fin_div = res.done;
      ST_FIN: begin
        emit      = 1'b1;
        fin_apply = 1'b1;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Carry out the command, write the color, build the result beat
  always_comb begin
    sets_next      = sets;
    dirty_next     = dirty;
    forced_next    = forced_active;
    flash_next     = flash_pending;
    phase_next     = ramp_phase;
    level_next     = ramp_level;
    step_cd_next   = step_cd;
    update_cd_next = update_cd;
    step_dec       = (step_cd != '0) ? step_cd - 8'd1 : step_cd;
    color_we       = 1'b0;
    color          = fin_rgb;
    active         = '0;
    out_next       = '0;

    if (exec) begin
      case (head.cmd.op)
        OP_TICK: begin
          if (update_cd != '0) begin
            update_cd_next = update_cd - 16'd1;
          end
          if (flash_pending) begin
            step_cd_next = step_dec;
            if (step_dec == '0) begin
              if (ramp_phase == PH_DELAY) begin
                flash_next = 1'b0;
                phase_next = '0;
                level_next = '0;
              end else begin
                color_we     = 1'b1;
                color        = ramp_color;
                phase_next   = phase_adv;
                level_next   = level_adv;
                step_cd_next = cfg.flash_step_ticks;
              end
            end
          end
        end
        OP_REPORT: begin
          if (report_go) begin
            update_cd_next = cfg.update_period;
          end
        end
        OP_FLASH: begin
          flash_next   = 1'b1;
          phase_next   = '0;
          level_next   = '0;
          step_cd_next = '0;
        end
        OP_FORCE: begin
          forced_next   = 1'b1;
          color_we      = 1'b1;
          color         = '{r: {1'b0, head.cmd.force_red},
                            g: {1'b0, head.cmd.force_green},
                            b: {1'b0, head.cmd.force_blue}};
          dirty_next[1] = 1'b1;
        end
        OP_RELEASE: begin
          forced_next   = 1'b0;
          dirty_next[0] = 1'b1;
        end
        default: begin
          forced_next = forced_active;
        end
      endcase
    end

    if (fin_apply) begin
      color_we = 1'b1;
    end

    // Write the active set and mark it changed
    if (color_we && (sets_next[forced_next] != color)) begin
      sets_next[forced_next]  = color;
      dirty_next[forced_next] = 1'b1;
    end

    if (emit) begin
      active                  = sets_next[forced_next];
      out_next.red_duty       = clamp_duty(active.r, cfg.duty_max);
      out_next.green_duty     = clamp_duty(active.g, cfg.duty_max);
      out_next.blue_duty      = clamp_duty(active.b, cfg.duty_max);
      out_next.write_strobe   = dirty_next[forced_next];
      out_next.animating      = flash_next;
      dirty_next[forced_next] = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sets[0]       <= '0;
      sets[1]       <= '0;
      dirty         <= '0;
      forced_active <= 1'b0;
      flash_pending <= 1'b1;
      ramp_phase    <= '0;
      ramp_level    <= '0;
      step_cd       <= '0;
      update_cd     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      sets          <= sets_next;
      dirty         <= dirty_next;
      forced_active <= forced_next;
      flash_pending <= flash_next;
      ramp_phase    <= phase_next;
      ramp_level    <= level_next;
      step_cd       <= step_cd_next;
      update_cd     <= update_cd_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load heat operands, final color and result beat
  always_ff @(posedge clk) begin
    if (exec && report_go) begin
      cur_r <= cur_clamp;
      tgt_r <= tgt_clamp;
    end
    if (fin_white) begin
      fin_rgb <= '{r: white, g: white, b: white};
    end else if (fin_div) begin
      fin_rgb <= '{r: res.quo,
                   g: '0,
                   b: COLOR_W'(m2 - res.quo - COLOR_W'(res.rem_nz))};
    end
    if (emit) begin
      out_data <= out_next;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

`ifndef SYNTHESIS
  a_fin_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |-> !out_valid)
    else $error("result register busy when heat color finishes");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    res.done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_flash_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !flash_pending |-> (ramp_phase == '0 && ramp_level == '0))
    else $error("ramp state left over after flash");
`endif

endmodule

[src/heat_status_rgb_led_driver.sv]
`timescale 1ns / 1ps
// Result path: an item taken from the command queue has its result registered; an evaluated
//   temperature report runs setup, 9-step divider and color write, and skips the divider when white.
// Throughput: one item per cycle from the command queue while the result register is free; an
//   evaluated report holds the back end through its setup, divider and color-write states.
// Reset (rst, synchronous): registers take their defaults, queue and result empty,
//   the start-up flash is pending and the first report after it is evaluated.

module heat_status_rgb_led_driver
  import hsled_pkg::*;
#(
  parameter int unsigned HOTEND_COUNT = HOTEND_COUNT_DEF
)
(
  input  logic                   clk,
  input  logic                   rst,
  hsled_in_if.sink               items,
  hsled_out_if.source            results,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t        cfg;
  queue_head_t head;
  logic        pop;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_max         <= LED_MAX;
      cfg.ambient_temp     <= AMBIENT_TEMP;
      cfg.heat_hysteresis  <= HEAT_HYSTERESIS;
      cfg.update_period    <= UPDATE_PERIOD;
      cfg.flash_step_ticks <= FLASH_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DUTY_MAX:         cfg.duty_max         <= cfg_data[7:0];
        CFG_AMBIENT_TEMP:     cfg.ambient_temp     <= cfg_data[6:0];
        CFG_HEAT_HYSTERESIS:  cfg.heat_hysteresis  <= cfg_data[5:0];
        CFG_UPDATE_PERIOD:    cfg.update_period    <= cfg_data[15:0];
        CFG_FLASH_STEP_TICKS: cfg.flash_step_ticks <= cfg_data[7:0];
        default:              cfg.duty_max         <= cfg.duty_max;
      endcase
    end
  end

  hsled_front u_front (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .pop   (pop),
    .head  (head)
  );

  hsled_back #(
    .HOTEND_COUNT (HOTEND_COUNT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench
  import hsled_pkg::*;
();

  localparam int unsigned HOTENDS           = HOTEND_COUNT_DEF;
  localparam int unsigned QUIET_LIMIT       = 5000;
  localparam int unsigned SETTLE_CYCLES     = 20;
  localparam int unsigned ITEMS_PER_SETTING = 50;
  localparam int unsigned HEAT_MAX          = 2047;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hsled_in_if  items ();
  hsled_out_if results ();

  heat_status_rgb_led_driver #(.HOTEND_COUNT(HOTENDS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register shadow of the LED driver
  logic [7:0]  duty_max;
  logic [6:0]  ambient_temp;
  logic [5:0]  hysteresis;
  logic [15:0] update_period;
  logic [7:0]  step_ticks;

  // LED driver state: color sets indexed by forced_on (normal, forced)
  logic [8:0]  color_set [2][3];
  bit          dirty [2];
  bit          forced_on;
  bit          flash_on;
  logic [2:0]  ramp_phase;
  logic [7:0]  ramp_level;
  logic [7:0]  step_left;
  logic [15:0] update_left;

  out_item_t pending_duties [$];

  int  send_idle_pct = 20;
  int  recv_idle_pct = 70;
  bit  allow_flash = 1'b1;
  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  heat_evals = 0;
  int  strobes = 0;
  int  settings_applied = 0;
  int  quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void driver_reset();
    duty_max      = LED_MAX;
    ambient_temp  = AMBIENT_TEMP;
    hysteresis    = HEAT_HYSTERESIS;
    update_period = UPDATE_PERIOD;
    step_ticks    = FLASH_STEP;
    for (int s = 0; s < 2; s++) begin
      dirty[s] = 1'b0;
      for (int c = 0; c < 3; c++) color_set[s][c] = '0;
    end
    forced_on   = 1'b0;
    flash_on    = 1'b1;
    ramp_phase  = '0;
    ramp_level  = '0;
    step_left   = '0;
    update_left = '0;
  endfunction

  // Write a color into the active set; mark the set only on a real change
  function automatic void paint(logic [8:0] r, logic [8:0] g, logic [8:0] b);
    int s;
    s = int'(forced_on);
    if (color_set[s][0] != r || color_set[s][1] != g || color_set[s][2] != b) begin
      color_set[s][0] = r;
      color_set[s][1] = g;
      color_set[s][2] = b;
      dirty[s] = 1'b1;
    end
  endfunction

  // Show the current ramp level, then advance level and phase
  function automatic void ramp_step();
    int lv;
    int ph;
    lv = int'(ramp_level);
    ph = int'(ramp_phase);
    if (ph >= PH_WHITE) begin
      paint(9'(lv), 9'(lv), 9'(lv));
    end else begin
      case (ph / 2)
        0:       paint(9'(lv), '0, '0);
        1:       paint('0, 9'(lv), '0);
        default: paint('0, '0, 9'(lv));
      endcase
    end
    if (ph % 2 == 0) begin
      // rising ramp
      if (lv + 1 >= duty_max) begin
        ph++;
        lv = (ph == PH_DELAY) ? 0 : int'(duty_max);
      end else begin
        lv++;
      end
    end else begin
      // falling ramp
      if (lv <= 1) begin
        ph++;
        lv = 0;
      end else begin
        lv--;
      end
    end
    ramp_phase = ph[2:0];
    ramp_level = lv[7:0];
    step_left  = step_ticks;
  endfunction

  function automatic void judge_heat(logic [10:0] cur_sum, logic [10:0] tgt_sum);
    int room;
    int cur;
    int tgt;
    int m2;
    room = HOTENDS * ambient_temp;
    cur  = int'(cur_sum) - room;
    tgt  = int'(tgt_sum) - room;
    m2   = 2 * duty_max;
    if (cur < 0) cur = 0;
    if (tgt < 0) tgt = 0;
    if (tgt == 0 || cur >= tgt - int'(hysteresis)) begin
      paint(9'(duty_max), 9'(duty_max), 9'(duty_max));
    end else begin
      paint(9'(m2 * cur / tgt), '0, 9'(m2 * (tgt - cur) / tgt));
    end
  endfunction

  // Apply one accepted beat and return the duties it should produce
  function automatic out_item_t led_predict(in_item_t it);
    out_item_t  r;
    int         s;
    logic [8:0] v;
    logic [7:0] shown [3];
    case (it.opcode)
      OP_TICK: begin
        if (update_left != 0) update_left--;
        if (flash_on) begin
          if (step_left != 0) step_left--;
          if (step_left == 0) begin
            if (ramp_phase == PH_DELAY) begin
              flash_on   = 1'b0;
              ramp_phase = '0;
              ramp_level = '0;
            end else begin
              ramp_step();
            end
          end
        end
      end
      OP_REPORT: begin
        if (!forced_on && !flash_on && update_left == 0) begin
          update_left = update_period;
          judge_heat(it.current_heat_sum, it.target_heat_sum);
          heat_evals++;
        end
      end
      OP_FLASH: begin
        flash_on   = 1'b1;
        ramp_phase = '0;
        ramp_level = '0;
        step_left  = '0;
      end
      OP_FORCE: begin
        forced_on = 1'b1;
        paint(9'(it.force_red), 9'(it.force_green), 9'(it.force_blue));
        dirty[1] = 1'b1;
      end
      OP_RELEASE: begin
        forced_on = 1'b0;
        dirty[0] = 1'b1;
      end
      default: ;
    endcase
    s = int'(forced_on);
    for (int c = 0; c < 3; c++) begin
      v = color_set[s][c];
      shown[c] = (v > duty_max) ? duty_max : v[7:0];
    end
    r.red_duty     = shown[0];
    r.green_duty   = shown[1];
    r.blue_duty    = shown[2];
    r.write_strobe = dirty[s];
    r.animating    = flash_on;
    dirty[s] = 1'b0;
    if (r.write_strobe) strobes++;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic in_item_t make_item(op_t op);
    in_item_t it;
    int       cur;
    int       tgt;
    it.opcode      = op;
    it.force_red   = 8'($urandom_range(255));
    it.force_green = 8'($urandom_range(255));
    it.force_blue  = 8'($urandom_range(255));
    if ($urandom_range(2) == 0) begin
      cur = $urandom_range(HEAT_MAX);
      tgt = $urandom_range(HEAT_MAX);
    end else begin
      // heating toward a target a little above room temperature
      tgt = HOTENDS * ambient_temp + $urandom_range(400);
      if (tgt > HEAT_MAX) tgt = HEAT_MAX;
      cur = $urandom_range(tgt + 8);
      if (cur > HEAT_MAX) cur = HEAT_MAX;
    end
    it.current_heat_sum = cur[10:0];
    it.target_heat_sum  = tgt[10:0];
    return it;
  endfunction

  function automatic in_item_t random_item();
    int  pick;
    op_t op;
    pick = $urandom_range(99);
    if (pick < 45)      op = OP_TICK;
    else if (pick < 76) op = OP_REPORT;
    else if (pick < 79) op = allow_flash ? OP_FLASH : OP_TICK;
    else if (pick < 88) op = OP_FORCE;
    else if (pick < 98) op = OP_RELEASE;
    else                op = OP_NOP;
    return make_item(op);
  endfunction

  // Present one beat from a falling edge and hold it until accepted
  task automatic send_item(in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      items.valid <= 1'b0;
      @(negedge clk);
    end
    items.valid <= 1'b1;
    items.data  <= it;
    @(posedge clk);
    while (items.ready !== 1'b1) @(posedge clk);
    pending_duties.push_back(led_predict(it));
    items_sent++;
  endtask

  task automatic send_op(op_t op);
    send_item(make_item(op));
  endtask

  task automatic send_report(int cur, int tgt);
    in_item_t it;
    it = make_item(OP_REPORT);
    it.current_heat_sum = 11'(cur);
    it.target_heat_sum  = 11'(tgt);
    send_item(it);
  endtask

  task automatic send_force(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_item_t it;
    it = make_item(OP_FORCE);
    it.force_red   = r;
    it.force_green = g;
    it.force_blue  = b;
    send_item(it);
  endtask

  // Tick until the running flash has played out
  task automatic finish_flash();
    while (flash_on) send_op(OP_TICK);
  endtask

  // Drop valid, wait for every outstanding result, then let the back end settle
  task automatic wait_for_results();
    @(negedge clk);
    items.valid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_DUTY_MAX:         duty_max      = val[7:0];
      CFG_AMBIENT_TEMP:     ambient_temp  = val[6:0];
      CFG_HEAT_HYSTERESIS:  hysteresis    = val[5:0];
      CFG_UPDATE_PERIOD:    update_period = val[15:0];
      CFG_FLASH_STEP_TICKS: step_ticks    = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [7:0] dmax, logic [6:0] room, logic [5:0] hyst,
                                logic [15:0] period, logic [7:0] step);
    wait_for_results();
    write_register(CFG_DUTY_MAX, 16'(dmax));
    write_register(CFG_AMBIENT_TEMP, 16'(room));
    write_register(CFG_HEAT_HYSTERESIS, 16'(hyst));
    write_register(CFG_UPDATE_PERIOD, period);
    write_register(CFG_FLASH_STEP_TICKS, 16'(step));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Small duty range keeps a flash short enough to finish between reports
  task automatic apply_small_settings();
    apply_settings(8'($urandom_range(1, 6)), 7'($urandom_range(0, 100)),
                   6'($urandom_range(0, 10)), 16'($urandom_range(1, 4)),
                   ($urandom_range(3) == 0) ? 8'd2 : 8'd1);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      // hold the sender once until the block has caught up
      if (i == count / 2) wait_for_results();
      send_item(random_item());
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Start-up flash at reset values: reports ignored, force and release pass
  task automatic test_startup_flash();
    send_op(OP_REPORT);
    send_op(OP_TICK);
    send_op(OP_TICK);
    send_force(8'hFF, 8'h00, 8'hFF);
    send_op(OP_REPORT);
    send_op(OP_RELEASE);
    send_op(OP_NOP);
    apply_settings(8'd1, 7'd0, 6'd0, 16'd1, 8'd1);
    finish_flash();
  endtask

  // Flash restart, force and release during a flash
  task automatic test_force_and_flash();
    send_op(OP_FLASH);
    send_op(OP_TICK);
    send_op(OP_FLASH);
    send_force(8'h00, 8'h00, 8'h00);
    send_op(OP_TICK);
    send_force(8'hFF, 8'hFF, 8'hFF);
    send_op(OP_RELEASE);
    finish_flash();
  endtask

  // Heat mapping at the register extremes
  task automatic test_heat_extremes();
    apply_settings(8'd255, 7'd100, 6'd63, 16'd1, 8'd255);
    send_report(0, 0);
    send_report(HEAT_MAX, HEAT_MAX);
    send_op(OP_TICK);
    send_report(0, HEAT_MAX);
    send_op(OP_TICK);
    send_report(HEAT_MAX, 0);
    send_op(OP_TICK);
    send_report(120, 200);
    send_op(OP_TICK);
    // right on the hysteresis edge, then one degree below it
    send_report(137, 200);
    send_op(OP_TICK);
    send_report(136, 200);
    send_op(OP_TICK);
    send_report(HEAT_MAX, HEAT_MAX);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, bit wide);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    apply_small_settings();
    run_random(ITEMS_PER_SETTING);
    apply_small_settings();
    run_random(ITEMS_PER_SETTING);
    // no flash at full duty range, it would outlast the phase
    finish_flash();
    allow_flash = 1'b0;
    if (wide) begin
      apply_settings(8'd255, 7'($urandom_range(0, 100)), 6'($urandom_range(0, 63)),
                     16'd1, 8'd1);
    end else begin
      apply_settings(8'd255, AMBIENT_TEMP, HEAT_HYSTERESIS, 16'hFFFF, 8'hFF);
    end
    run_random(ITEMS_PER_SETTING / 2);
    allow_flash = 1'b1;
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(negedge clk) begin
    results.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    out_item_t got;
    if (rst === 1'b0 && results.valid === 1'b1 && results.ready === 1'b1) begin
      got = results.data;
      results_seen++;
      if (pending_duties.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual %p", $time, got);
      end else begin
        want = pending_duties.pop_front();
        check_field("red_duty", want.red_duty, got.red_duty);
        check_field("green_duty", want.green_duty, got.green_duty);
        check_field("blue_duty", want.blue_duty, got.blue_duty);
        check_field("write_strobe", 8'(want.write_strobe), 8'(got.write_strobe));
        check_field("animating", 8'(want.animating), 8'(got.animating));
      end
    end
  end

  // Count cycles with no beat on either channel
  always @(posedge clk) begin
    if ((items.valid === 1'b1 && items.ready === 1'b1) ||
        (results.valid === 1'b1 && results.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t ns: no beat for %0d cycles", $time, QUIET_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    items.valid   = 1'b0;
    items.data    = '0;
    results.ready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_DUTY_MAX;
    cfg_data      = '0;
    rst           = 1'b1;
    driver_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_startup_flash();
    test_force_and_flash();
    test_heat_extremes();
    test_random_traffic(20, 70, 1'b1);
    test_random_traffic(70, 20, 1'b1);
    test_random_traffic(0, 0, 1'b0);
    wait_for_results();

    $display("Covered %0d items, %0d results, %0d register settings incl. extremes.",
             items_sent, results_seen, settings_applied);
    $display("Evaluated %0d heat reports; %0d color writes; flash, force, release mixed in.",
             heat_evals, strobes);
    if (errors == 0 && pending_duties.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[sim.f]
src/hsled_pkg.sv
src/hsled_if.sv
src/hsled_front.sv
src/hsled_div.sv
src/hsled_back.sv
src/heat_status_rgb_led_driver.sv
tb/testbench.sv
